[rtl/core/hhds_pkg.sv]
// Shared types and constants of the HTTP header delimiter scanner.
// No dependencies; every other file of the block but hhds_in_if imports this package.
package hhds_pkg;

    // Widths of the result fields.
    localparam int unsigned POS_W = 10;
    localparam int unsigned IDX_W = 5;

    // Delimiter characters.
    localparam logic [7:0] C_COLON = 8'h3A;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_SPACE = 8'h20;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_NAME  = 2'd1,
        EV_VALUE = 2'd2,
        EV_END   = 2'd3
    } t_event;

    typedef struct packed {
        t_event             event_res;
        logic [POS_W-1:0]   position;
        logic [IDX_W-1:0]   entry_index;
        logic               terminator_mark;
        logic               table_full;
        logic               offset_overflow;
    } t_result;

endpackage

[rtl/core/hhds_in_if.sv]
// Input byte channel of the HTTP header delimiter scanner.
// Depends on nothing but the valid/ready handshake convention.
interface hhds_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

[rtl/core/hhds_out_if.sv]
// Result channel of the HTTP header delimiter scanner.
// Depends on hhds_pkg for the event type and field widths.
interface hhds_out_if import hhds_pkg::*; ();
    logic               valid;
    logic               ready;
    t_event             event_res;
    logic [POS_W-1:0]   position;
    logic [IDX_W-1:0]   entry_index;
    logic               terminator_mark;
    logic               table_full;
    logic               offset_overflow;

    modport source (
        output valid, output event_res, output position, output entry_index,
        output terminator_mark, output table_full, output offset_overflow,
        input ready
    );
    modport sink (
        input valid, input event_res, input position, input entry_index,
        input terminator_mark, input table_full, input offset_overflow,
        output ready
    );
endinterface

[rtl/core/http_header_delimiter_scanner_top.sv]
// Top level of the HTTP response head delimiter scanner.
// Depends on hhds_pkg, hhds_in_if, hhds_out_if, hhds_scan and hhds_out_buf.
//
//   Channel  Direction  Payload                                     Per transfer
//   i_in     in         data_byte                                   one head byte
//   o_out    out        event_res, position, entry_index,           one result
//                       terminator_mark, table_full, offset_overflow
//
// Every accepted byte yields exactly one result. The byte is classified and the
// parser state updated in the cycle of its transfer; the result is registered in
// the output buffer before it is visible on o_out. One byte per cycle is
// sustained while the buffer has room, set by the single state update per byte.
// A two-entry output buffer lets the input keep flowing while one result waits,
// so i_in.ready drops only when two results are held. Reset (i_rst_n low at a
// clock edge) returns the parser to the start of a head and empties the buffer.
module http_header_delimiter_scanner_top import hhds_pkg::*; #(
    parameter int unsigned MAX_ENTRIES = 32,
    parameter int unsigned HEAD_BYTES  = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    hhds_in_if.sink        i_in,
    hhds_out_if.source     o_out
);

    // A transfer on the input channel advances the parser state.
    logic    w_accept;
    logic    w_in_ready;
    t_result w_scan_result;
    t_result w_out_data;
    logic    w_out_valid;

    assign w_accept   = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    // Classification of the byte and the header parser state.
    hhds_scan #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .HEAD_BYTES  (HEAD_BYTES)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (i_in.data_byte),
        .o_result    (w_scan_result)
    );

    // Result register with a skid stage toward the consumer.
    hhds_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (i_in.valid),
        .o_push_ready (w_in_ready),
        .i_push_data  (w_scan_result),
        .o_valid      (w_out_valid),
        .i_ready      (o_out.ready),
        .o_data       (w_out_data)
    );

    // Unpack the held result onto the output channel.
    assign o_out.valid           = w_out_valid;
    assign o_out.event_res       = w_out_data.event_res;
    assign o_out.position        = w_out_data.position;
    assign o_out.entry_index     = w_out_data.entry_index;
    assign o_out.terminator_mark = w_out_data.terminator_mark;
    assign o_out.table_full      = w_out_data.table_full;
    assign o_out.offset_overflow = w_out_data.offset_overflow;

endmodule

[rtl/core/hhds_scan.sv]
// Parser state and per-byte classification of the header scanner.
// Depends on hhds_pkg; the result is captured by the output buffer.
module hhds_scan import hhds_pkg::*; #(
    parameter int unsigned MAX_ENTRIES = 32,
    parameter int unsigned HEAD_BYTES  = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    output t_result     o_result
);

    localparam int unsigned OW  = $clog2(HEAD_BYTES + 1);
    localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned PW  = (OW > POS_W) ? OW : POS_W;
    localparam int unsigned XW  = (CW > IDX_W) ? CW : IDX_W;

    logic [OW-1:0] r_byte_offset, n_byte_offset;
    logic [CW-1:0] r_entry_count, n_entry_count;
    logic          r_awaiting_name, n_awaiting_name;
    logic          r_awaiting_value, n_awaiting_value;
    logic          r_status_line_pending, n_status_line_pending;
    logic          r_inside_value, n_inside_value;
    logic [1:0]    r_return_count, n_return_count;
    logic [1:0]    r_newline_count, n_newline_count;

    logic          w_ovf;
    logic [OW-1:0] w_pos;
    logic [CW-1:0] w_idx;
    logic [PW-1:0] w_pos_ext;
    logic [XW-1:0] w_idx_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_offset         <= '0;
            r_entry_count         <= '0;
            r_awaiting_name       <= 1'b1;
            r_awaiting_value      <= 1'b0;
            r_status_line_pending <= 1'b1;
            r_inside_value        <= 1'b0;
            r_return_count        <= '0;
            r_newline_count       <= '0;
        end else if (i_accept) begin
            r_byte_offset         <= n_byte_offset;
            r_entry_count         <= n_entry_count;
            r_awaiting_name       <= n_awaiting_name;
            r_awaiting_value      <= n_awaiting_value;
            r_status_line_pending <= n_status_line_pending;
            r_inside_value        <= n_inside_value;
            r_return_count        <= n_return_count;
            r_newline_count       <= n_newline_count;
        end
    end

    always_comb begin
        n_byte_offset         = r_byte_offset;
        n_entry_count         = r_entry_count;
        n_awaiting_name       = r_awaiting_name;
        n_awaiting_value      = r_awaiting_value;
        n_status_line_pending = r_status_line_pending;
        n_inside_value        = r_inside_value;
        n_return_count        = r_return_count;
        n_newline_count       = r_newline_count;

        o_result.event_res       = EV_NONE;
        o_result.terminator_mark = 1'b0;
        o_result.table_full      = 1'b0;
        w_idx                    = '0;

        // The offset counter parks at the buffer size.
        w_ovf = (r_byte_offset >= OW'(HEAD_BYTES));
        w_pos = w_ovf ? OW'(HEAD_BYTES - 1) : r_byte_offset;
        if (!w_ovf) begin
            n_byte_offset = r_byte_offset + OW'(1);
        end

        if (i_data_byte == C_COLON) begin
            if (!r_inside_value) begin
                o_result.terminator_mark = 1'b1;
                n_awaiting_value         = 1'b1;
            end
        end else if (i_data_byte == C_CR) begin
            o_result.terminator_mark = 1'b1;
            n_return_count = (r_return_count == 2'd3) ? 2'd3 : r_return_count + 2'd1;
            n_inside_value = 1'b0;
        end else if (i_data_byte == C_LF) begin
            n_newline_count = (r_newline_count == 2'd3) ? 2'd3 : r_newline_count + 2'd1;
            n_awaiting_name = 1'b1;
            n_inside_value  = 1'b0;
            // Blank line: second CR already seen and this is the second LF.
            if (r_return_count == 2'd2 && r_newline_count == 2'd1) begin
                o_result.event_res    = EV_END;
                n_byte_offset         = '0;
                n_entry_count         = '0;
                n_awaiting_name       = 1'b1;
                n_awaiting_value      = 1'b0;
                n_status_line_pending = 1'b1;
                n_inside_value        = 1'b0;
                n_return_count        = '0;
                n_newline_count       = '0;
            end
        end else begin
            n_return_count  = '0;
            n_newline_count = '0;
            if (i_data_byte == C_SPACE) begin
                if (r_status_line_pending) begin
                    o_result.terminator_mark = 1'b1;
                    n_awaiting_value         = 1'b1;
                    n_status_line_pending    = 1'b0;
                end
            end else if (r_awaiting_name) begin
                n_awaiting_name = 1'b0;
                if (r_entry_count >= CW'(MAX_ENTRIES)) begin
                    o_result.table_full = 1'b1;
                end else begin
                    o_result.event_res = EV_NAME;
                    w_idx              = r_entry_count;
                    n_entry_count      = r_entry_count + CW'(1);
                end
            end else if (r_awaiting_value) begin
                o_result.event_res = EV_VALUE;
                w_idx = (r_entry_count == '0) ? '0 : r_entry_count - CW'(1);
                n_inside_value   = 1'b1;
                n_awaiting_value = 1'b0;
            end
        end

        w_pos_ext = PW'(w_pos);
        w_idx_ext = XW'(w_idx);
        o_result.position        = w_pos_ext[POS_W-1:0];
        o_result.entry_index     = w_idx_ext[IDX_W-1:0];
        o_result.offset_overflow = w_ovf;
    end

    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_result.event_res == EV_END) |=>
        (r_byte_offset == '0 && r_entry_count == '0 && r_status_line_pending))
        else $error("state not restored after end of head");

    a_entry_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entry_count <= CW'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    a_full_only_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_result.table_full) |-> (r_entry_count == CW'(MAX_ENTRIES)))
        else $error("table full reported with free entries");

    a_offset_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_offset <= OW'(HEAD_BYTES))
        else $error("byte offset passed its saturation point");

endmodule

[rtl/core/hhds_out_buf.sv]
// Two-entry output buffer (result register plus skid stage) of the scanner.
// Depends on hhds_pkg for the result type.
module hhds_out_buf import hhds_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push_valid,
    output logic    o_push_ready,
    input  t_result i_push_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic [1:0] r_count, n_count;
    t_result    r_head, n_head;
    t_result    r_skid, n_skid;
    logic       w_push;
    logic       w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_valid      = (r_count != 2'd0);
    assign o_data       = r_head;
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_skid <= n_skid;
    end

    always_comb begin
        n_head  = r_head;
        n_skid  = r_skid;
        n_count = r_count;
        unique case (r_count)
            2'd0: begin
                if (w_push) begin
                    n_head  = i_push_data;
                    n_count = 2'd1;
                end
            end
            2'd1: begin
                if (w_push && w_pop) begin
                    n_head = i_push_data;
                end else if (w_push) begin
                    n_skid  = i_push_data;
                    n_count = 2'd2;
                end else if (w_pop) begin
                    n_count = 2'd0;
                end
            end
            2'd2: begin
                if (w_pop) begin
                    n_head  = r_skid;
                    n_count = 2'd1;
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("output buffer overfilled");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == 2'($past(r_count) + 2'd1)))
        else $error("transfer into buffer lost");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_count == 2'($past(r_count) - 2'd1)))
        else $error("transfer out of buffer not retired");

endmodule
